// ===== design/sns_pkg.sv =====
// ----------------------------------------------------------------------------
// sns_pkg
// Shared types, constants and helpers for the sigmoid neuron training step.
// ----------------------------------------------------------------------------
package sns_pkg;

	localparam int FRAC_BITS = 12;
	localparam int SIG_DEPTH = 256;
	localparam int IDX_W     = $clog2(SIG_DEPTH);
	localparam int DATA_W    = 16;
	localparam int LR_W      = 13;
	localparam int CFG_IDX_W = 4;
	localparam int MUL_W     = 32;
	localparam int P_W       = 2 * MUL_W;
	localparam int ACC_W     = 36;
	localparam int E_W       = 16 + (16 - FRAC_BITS) + 2;
	localparam int G_W       = 20;
	localparam int PQ_W      = 31;

	localparam logic [LR_W-1:0]          RST_LEARN_RATE = 13'd410;
	localparam logic signed [DATA_W-1:0] RST_WEIGHT_0   = 16'sd6799;
	localparam logic signed [DATA_W-1:0] RST_WEIGHT_1   = -16'sd1434;
	localparam logic signed [DATA_W-1:0] RST_BIAS       = 16'sd0;

	localparam logic signed [P_W-1:0] SAT_HI = P_W'(32767);
	localparam logic signed [P_W-1:0] SAT_LO = -P_W'(32768);
	localparam logic signed [P_W-1:0] SQ_MAX = P_W'(65535);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEARN_RATE = 4'd0,
		CFG_INIT_W0    = 4'd1,
		CFG_INIT_W1    = 4'd2,
		CFG_INIT_BIAS  = 4'd3
	} sns_cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_WX0, S_WX1, S_ACC, S_SIG, S_ERR, S_PQ, S_EE,
		S_EPQ, S_G, S_GW0, S_GW1, S_UB, S_UW0, S_UW1, S_DONE
	} sns_state_t;

	typedef struct packed {
		sns_state_t state;
		logic       in_ready;
	} sns_ctl_t;

	typedef logic [15:0] sig_tab_t [SIG_DEPTH];

	// restoring division, table build only
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo, rem;
		int              b;
		quo = 0;
		rem = 0;
		for (b = 63; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & 64'd1);
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | (64'd1 << b);
			end
		end
		return quo;
	endfunction

	// e^-a series evaluation and rounded divide, all at elaboration
	function automatic sig_tab_t build_sig_table();
		sig_tab_t            tab;
		longint              c;
		longint unsigned     mag, y, n, r, term, sum, e, d, p, j;
		longint unsigned     one_q32, log2e_q32, ln2_q32;
		int                  k;
		one_q32   = 64'd4294967296;
		log2e_q32 = 64'd6196328019;
		ln2_q32   = 64'd2977044472;
		for (k = 0; k < SIG_DEPTH; k++) begin
			c = (longint'(2 * k + 1) * 65536) / (2 * SIG_DEPTH) - 32768;
			mag = (c < 0) ? longint'(-c) : longint'(c);
			y = (mag * log2e_q32) >> FRAC_BITS;
			n = y >> 32;
			r = ((y & 64'hFFFF_FFFF) * ln2_q32) >> 32;
			if (n >= 63) begin
				e = 0;
			end else begin
				term = one_q32;
				sum  = one_q32;
				for (j = 1; j <= 12; j++) begin
					term = udiv64((term * r) >> 32, j);
					if (j[0]) sum = sum - term;
					else sum = sum + term;
				end
				e = sum >> n;
			end
			d = one_q32 + e;
			if (c >= 0) p = udiv64((one_q32 << 16) + d / 2, d);
			else p = udiv64((e << 16) + d / 2, d);
			if (p > 65535) p = 65535;
			tab[k] = p[15:0];
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

	// round half up, then floor
	function automatic logic signed [P_W-1:0] rnd_shr(input logic signed [P_W-1:0] v,
			input int s);
		logic signed [P_W-1:0] half;
		half = $signed(P_W'(1) << (s - 1));
		return (v + half) >>> s;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat16(input logic signed [P_W-1:0] v);
		logic signed [DATA_W-1:0] res;
		if (v > SAT_HI) res = 16'sh7FFF;
		else if (v < SAT_LO) res = -16'sh8000;
		else res = v[DATA_W-1:0];
		return res;
	endfunction

	function automatic logic ovf16(input logic signed [P_W-1:0] v);
		return (v > SAT_HI) || (v < SAT_LO);
	endfunction

endpackage

// ===== design/sns_in_if.sv =====
// ----------------------------------------------------------------------------
// sns_in_if
// Sample request channel: two features, target and reload flag.
// ----------------------------------------------------------------------------
interface sns_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [sns_pkg::DATA_W-1:0]  feature_0;
	logic signed [sns_pkg::DATA_W-1:0]  feature_1;
	logic signed [sns_pkg::DATA_W-1:0]  target_value;
	logic                               reload;

	modport source (output valid, feature_0, feature_1, target_value, reload, input ready);
	modport sink (input valid, feature_0, feature_1, target_value, reload, output ready);
endinterface

// ===== design/sns_out_if.sv =====
// ----------------------------------------------------------------------------
// sns_out_if
// Result request channel: prediction, error, gradients and clip flag.
// ----------------------------------------------------------------------------
interface sns_out_if;
	logic                               valid;
	logic                               ready;
	logic [sns_pkg::DATA_W-1:0]         prediction;
	logic [sns_pkg::DATA_W-1:0]         squared_error;
	logic signed [sns_pkg::DATA_W-1:0]  grad_bias;
	logic signed [sns_pkg::DATA_W-1:0]  grad_weight0;
	logic signed [sns_pkg::DATA_W-1:0]  grad_weight1;
	logic                               clipped;

	modport source (output valid, prediction, squared_error, grad_bias, grad_weight0,
		grad_weight1, clipped, input ready);
	modport sink (input valid, prediction, squared_error, grad_bias, grad_weight0,
		grad_weight1, clipped, output ready);
endinterface

// ===== design/sns_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sns_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sns_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [sns_pkg::CFG_IDX_W-1:0]       index;
	logic [sns_pkg::DATA_W-1:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/sns_mul.sv =====
// ----------------------------------------------------------------------------
// sns_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module sns_mul (
	input  logic                              clk,
	input  logic signed [sns_pkg::MUL_W-1:0]  a,
	input  logic signed [sns_pkg::MUL_W-1:0]  b,
	output logic signed [sns_pkg::P_W-1:0]    prod_q
);
	import sns_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= P_W'(a) * P_W'(b);
	end

endmodule

// ===== design/sns_seq.sv =====
// ----------------------------------------------------------------------------
// sns_seq
// Step sequencer: walks one sample through the shared multiplier.
// ----------------------------------------------------------------------------
module sns_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_free,
	output sns_pkg::sns_ctl_t  ctl
);
	import sns_pkg::*;

	sns_state_t state_q;
	sns_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl.state    = state_q;
		ctl.in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				ctl.in_ready = 1'b1;
				if (in_valid) state_d = S_WX0;
			end
			S_WX0: state_d = S_WX1;
			S_WX1: state_d = S_ACC;
			S_ACC: state_d = S_SIG;
			S_SIG: state_d = S_ERR;
			S_ERR: state_d = S_PQ;
			S_PQ:  state_d = S_EE;
			S_EE:  state_d = S_EPQ;
			S_EPQ: state_d = S_G;
			S_G:   state_d = S_GW0;
			S_GW0: state_d = S_GW1;
			S_GW1: state_d = S_UB;
			S_UB:  state_d = S_UW0;
			S_UW0: state_d = S_UW1;
			S_UW1: state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== design/sigmoid_neuron_sgd_step.sv =====
// ----------------------------------------------------------------------------
// sigmoid_neuron_sgd_step
// One gradient descent step of a two-input sigmoid neuron per sample.
// ----------------------------------------------------------------------------
// in_ch carries one sample per request (features, target, reload flag).
// out_ch returns one result per sample: prediction, squared error, the
// three gradients and a clip flag. cfg writes learn_rate (index 0) and the
// initial weight and bias values (indexes 1 to 3); it is always ready, and
// the user must write it only while the block is idle; this is not enforced.
// A sample goes through fifteen steps around one shared 32x32 multiplier;
// a new sample is taken only once the block is back in idle after the
// last step of the previous one. The steps follow the multiplier chain
// (products, sigmoid error, gradient, three updates).
// If out_ch stalls, the block holds its last step until the previous
// result is taken; the result register lets the next sample in meanwhile.
// Reset restores the register and parameter reset values and idles.
// ----------------------------------------------------------------------------
module sigmoid_neuron_sgd_step (
	input  logic      clk,
	input  logic      arst_n,
	sns_in_if.sink    in_ch,
	sns_out_if.source out_ch,
	sns_cfg_if.sink   cfg
);
	import sns_pkg::*;

	sns_ctl_t ctl;
	logic     accept;
	logic     out_free;

	logic [LR_W-1:0]          lr_q;
	logic signed [DATA_W-1:0] init_w0_q, init_w1_q, init_b_q;
	logic signed [DATA_W-1:0] wa_q, wb_q, bias_q;

	logic signed [DATA_W-1:0] x0_q, x1_q, t_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [DATA_W-1:0]        p_q;
	logic [DATA_W:0]          q_q;
	logic signed [E_W-1:0]    e_q;
	logic [PQ_W-1:0]          pq_q;
	logic [DATA_W-1:0]        sq_q;
	logic signed [G_W-1:0]    g_q;
	logic signed [DATA_W-1:0] gb_q, gw0_q, gw1_q;
	logic                     clip_q;

	logic                     out_valid_q;
	logic [DATA_W-1:0]        o_pred_q, o_sq_q;
	logic signed [DATA_W-1:0] o_gb_q, o_gw0_q, o_gw1_q;
	logic                     o_clip_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [P_W-1:0]    prod_q;

	logic signed [P_W-1:0]    z_full, sq_full, g_full, prod_rnd, upd_val;
	logic signed [DATA_W-1:0] z_sat, upd_sel;
	logic [DATA_W-1:0]        z_u;
	logic [16+IDX_W:0]        idx_prod;
	logic [IDX_W-1:0]         idx;

	assign accept   = in_ch.valid && ctl.in_ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign cfg.ready = 1'b1;

	sns_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.out_free (out_free),
		.ctl      (ctl)
	);

	sns_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign in_ch.ready = ctl.in_ready;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.state)
			S_WX0: begin mul_a = MUL_W'(wa_q);  mul_b = MUL_W'(x0_q); end
			S_WX1: begin mul_a = MUL_W'(wb_q);  mul_b = MUL_W'(x1_q); end
			S_PQ:  begin mul_a = MUL_W'(p_q);   mul_b = MUL_W'(q_q);  end
			S_EE:  begin mul_a = MUL_W'(e_q);   mul_b = MUL_W'(e_q);  end
			S_EPQ: begin mul_a = MUL_W'(e_q);   mul_b = MUL_W'(pq_q); end
			S_GW0: begin mul_a = MUL_W'(g_q);   mul_b = MUL_W'(x0_q); end
			S_GW1: begin mul_a = MUL_W'(g_q);   mul_b = MUL_W'(x1_q); end
			S_UB:  begin mul_a = MUL_W'(lr_q);  mul_b = MUL_W'(gb_q); end
			S_UW0: begin mul_a = MUL_W'(lr_q);  mul_b = MUL_W'(gw0_q); end
			// held through a stalled final step
			S_UW1, S_DONE: begin mul_a = MUL_W'(lr_q);  mul_b = MUL_W'(gw1_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		z_full   = rnd_shr(P_W'(acc_q), FRAC_BITS);
		z_sat    = sat16(z_full);
		z_u      = {~z_sat[DATA_W-1], z_sat[DATA_W-2:0]};
		idx_prod = (17 + IDX_W)'(z_u) * (17 + IDX_W)'(SIG_DEPTH);
		idx      = idx_prod[16 +: IDX_W];
		sq_full  = rnd_shr(prod_q, 32 - FRAC_BITS);
		// factor two folded into the shift
		g_full   = rnd_shr(prod_q, 47 - FRAC_BITS);
		prod_rnd = rnd_shr(prod_q, FRAC_BITS);
		case (ctl.state)
			S_UW0:   upd_sel = bias_q;
			S_UW1:   upd_sel = wa_q;
			default: upd_sel = wb_q;
		endcase
		upd_val  = P_W'(upd_sel) - prod_rnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q      <= RST_LEARN_RATE;
			init_w0_q <= RST_WEIGHT_0;
			init_w1_q <= RST_WEIGHT_1;
			init_b_q  <= RST_BIAS;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LEARN_RATE: lr_q      <= cfg.data[LR_W-1:0];
				CFG_INIT_W0:    init_w0_q <= $signed(cfg.data);
				CFG_INIT_W1:    init_w1_q <= $signed(cfg.data);
				CFG_INIT_BIAS:  init_b_q  <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_q   <= RST_WEIGHT_0;
			wb_q   <= RST_WEIGHT_1;
			bias_q <= RST_BIAS;
		end else begin
			if (accept && in_ch.reload) begin
				wa_q   <= init_w0_q;
				wb_q   <= init_w1_q;
				bias_q <= init_b_q;
			end
			if (ctl.state == S_UW0) bias_q <= sat16(upd_val);
			if (ctl.state == S_UW1) wa_q <= sat16(upd_val);
			if (ctl.state == S_DONE && out_free) wb_q <= sat16(upd_val);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q <= in_ch.feature_0;
			x1_q <= in_ch.feature_1;
			t_q  <= in_ch.target_value;
		end
		case (ctl.state)
			S_WX0: acc_q <= ACC_W'(bias_q) <<< FRAC_BITS;
			S_WX1: acc_q <= acc_q + ACC_W'(prod_q);
			S_ACC: acc_q <= acc_q + ACC_W'(prod_q);
			S_SIG: begin
				p_q    <= SIG_TABLE[idx];
				clip_q <= ovf16(z_full);
			end
			S_ERR: begin
				e_q <= $signed({{(E_W-DATA_W){1'b0}}, p_q})
					- ($signed(E_W'(t_q)) <<< (16 - FRAC_BITS));
				q_q <= 17'h10000 - {1'b0, p_q};
			end
			S_EE: pq_q <= prod_q[PQ_W-1:0];
			S_EPQ: begin
				if (sq_full > SQ_MAX) begin
					sq_q   <= 16'hFFFF;
					clip_q <= 1'b1;
				end else begin
					sq_q <= sq_full[DATA_W-1:0];
				end
			end
			S_G: begin
				g_q    <= g_full[G_W-1:0];
				gb_q   <= sat16(g_full);
				clip_q <= clip_q | ovf16(g_full);
			end
			S_GW1: begin
				gw0_q  <= sat16(prod_rnd);
				clip_q <= clip_q | ovf16(prod_rnd);
			end
			S_UB: begin
				gw1_q  <= sat16(prod_rnd);
				clip_q <= clip_q | ovf16(prod_rnd);
			end
			S_UW0, S_UW1: clip_q <= clip_q | ovf16(upd_val);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.state == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.state == S_DONE && out_free) begin
			o_pred_q <= p_q;
			o_sq_q   <= sq_q;
			o_gb_q   <= gb_q;
			o_gw0_q  <= gw0_q;
			o_gw1_q  <= gw1_q;
			o_clip_q <= clip_q | ovf16(upd_val);
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.prediction    = o_pred_q;
	assign out_ch.squared_error = o_sq_q;
	assign out_ch.grad_bias     = o_gb_q;
	assign out_ch.grad_weight0  = o_gw0_q;
	assign out_ch.grad_weight1  = o_gw1_q;
	assign out_ch.clipped       = o_clip_q;

endmodule

// ===== design/sns_checker.sv =====
// ----------------------------------------------------------------------------
// sns_checker
// Port-level checks for the neuron training step, bound to the top level.
// ----------------------------------------------------------------------------
module sns_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [sns_pkg::DATA_W-1:0]         prediction,
	input logic signed [sns_pkg::DATA_W-1:0]  grad_bias
);

	// input ready drops right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accept");

	// no result appears on the edge right after a request is taken
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(prediction) && $stable(grad_bias))
		else $error("result changed under stall");

endmodule

bind sigmoid_neuron_sgd_step sns_checker u_sns_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.prediction (out_ch.prediction),
	.grad_bias  (out_ch.grad_bias)
);

// ===== verif/sigmoid_neuron_sgd_step_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigmoid_neuron_sgd_step_tb
// Self-checking bench for the two-input sigmoid neuron training step. A local
// fixed-point predictor keeps its own weights, bias and register copies, and
// queues one expected result per accepted sample. Directed cases cover the
// reset state, field extremes and every register. Random training runs follow
// under several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module sigmoid_neuron_sgd_step_tb;
	import sns_pkg::*;

	localparam int LIMIT_CYCLES  = 1000000;
	localparam int SETTLE_CYCLES = 24;
	localparam int PRINT_CAP     = 40;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 150;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 4'd4;
	localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;
	localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7FFF;

	localparam longint unsigned LOG2E_Q32 = 64'd6196328019;
	localparam longint unsigned LN2_Q32   = 64'd2977044472;
	localparam longint unsigned ONE_Q32   = 64'd4294967296;

	typedef struct {
		logic signed [DATA_W-1:0] x0;
		logic signed [DATA_W-1:0] x1;
		logic signed [DATA_W-1:0] tgt;
		logic                     reload;
	} sample_t;

	typedef struct {
		logic [DATA_W-1:0]        pred;
		logic [DATA_W-1:0]        sqerr;
		logic signed [DATA_W-1:0] gb;
		logic signed [DATA_W-1:0] gw0;
		logic signed [DATA_W-1:0] gw1;
		logic                     clip;
	} neuron_result_t;

	logic clk;
	logic arst_n;

	sns_in_if  in_ch();
	sns_out_if out_ch();
	sns_cfg_if cfg();

	sigmoid_neuron_sgd_step uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	longint lr_st, init_w0_st, init_w1_st, init_b_st;
	longint w0_st, w1_st, b_st;
	logic [DATA_W-1:0] sig_lut [SIG_DEPTH];

	neuron_result_t pending_results[$];
	int  mismatches    = 0;
	int  result_count  = 0;
	int  cycle_count   = 0;
	int  stall_left    = 0;
	bit  in_gaps_on    = 1'b1;
	bit  out_stalls_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("timeout after %0d cycles, %0d results pending", cycle_count,
			pending_results.size());
		$display("** sigmoid_neuron_sgd_step: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------
	function automatic void build_sig_lut();
		longint          c;
		longint unsigned mag, y, n, r, term, sum, e, d, p, j;
		int              k;
		for (k = 0; k < SIG_DEPTH; k++) begin
			c = (longint'(2 * k + 1) * 65536) / (2 * SIG_DEPTH) - 32768;
			mag = (c < 0) ? -c : c;
			y = (mag * LOG2E_Q32) >> FRAC_BITS;
			n = y >> 32;
			r = ((y & 64'hFFFF_FFFF) * LN2_Q32) >> 32;
			term = ONE_Q32;
			sum = ONE_Q32;
			for (j = 1; j <= 12; j++) begin
				term = ((term * r) >> 32) / j;
				if (j % 2 == 1) sum -= term;
				else sum += term;
			end
			e = (n >= 63) ? 64'd0 : (sum >> n);
			d = ONE_Q32 + e;
			if (c >= 0) p = ((ONE_Q32 << 16) + d / 2) / d;
			else p = ((e << 16) + d / 2) / d;
			sig_lut[k] = (p > 65535) ? 16'hFFFF : p[15:0];
		end
	endfunction

	function automatic longint round_half_up(input longint v, input int s);
		if (s == 0) return v;
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic bit over_q(input longint v);
		return (v > 32767) || (v < -32768);
	endfunction

	function automatic longint clamp_q(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [DATA_W-1:0] data);
		case (idx)
			CFG_LEARN_RATE: lr_st = data[LR_W-1:0];
			CFG_INIT_W0:    init_w0_st = $signed(data);
			CFG_INIT_W1:    init_w1_st = $signed(data);
			CFG_INIT_BIAS:  init_b_st = $signed(data);
			default: ;
		endcase
	endfunction

	function automatic neuron_result_t train_step(input sample_t it);
		longint         x0, x1, t, acc, z, idx, p, q, e16, sq, g, gb, gw0, gw1, nxt;
		bit             clip;
		neuron_result_t r;
		x0 = it.x0;
		x1 = it.x1;
		t = it.tgt;
		clip = 1'b0;
		if (it.reload) begin
			w0_st = init_w0_st;
			w1_st = init_w1_st;
			b_st = init_b_st;
		end
		acc = w0_st * x0 + w1_st * x1 + b_st * (longint'(1) <<< FRAC_BITS);
		z = round_half_up(acc, FRAC_BITS);
		clip |= over_q(z);
		z = clamp_q(z);
		idx = ((z + 32768) * SIG_DEPTH) >>> 16;
		p = sig_lut[idx];
		q = 65536 - p;

		e16 = p - t * (longint'(1) <<< (16 - FRAC_BITS));
		sq = round_half_up(e16 * e16, 32 - FRAC_BITS);
		if (sq > 65535) begin
			sq = 65535;
			clip = 1'b1;
		end

		g = round_half_up(2 * e16 * (p * q), 48 - FRAC_BITS);
		gw0 = round_half_up(g * x0, FRAC_BITS);
		gw1 = round_half_up(g * x1, FRAC_BITS);
		clip |= over_q(gw0) | over_q(gw1) | over_q(g);
		gw0 = clamp_q(gw0);
		gw1 = clamp_q(gw1);
		gb = clamp_q(g);

		nxt = b_st - round_half_up(lr_st * gb, FRAC_BITS);
		clip |= over_q(nxt);
		b_st = clamp_q(nxt);
		nxt = w0_st - round_half_up(lr_st * gw0, FRAC_BITS);
		clip |= over_q(nxt);
		w0_st = clamp_q(nxt);
		nxt = w1_st - round_half_up(lr_st * gw1, FRAC_BITS);
		clip |= over_q(nxt);
		w1_st = clamp_q(nxt);

		r.pred = p[15:0];
		r.sqerr = sq[15:0];
		r.gb = gb[15:0];
		r.gw0 = gw0[15:0];
		r.gw1 = gw1[15:0];
		r.clip = clip;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// channel drivers and result check
	// ------------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP) $display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (got !== want)
			report($sformatf("result %0d %s: got %h, expected %h", result_count, name,
				got, want));
	endtask

	task automatic send_item(input logic signed [DATA_W-1:0] x0, x1, tgt,
			input logic rl);
		sample_t it;
		int      gap;
		it.x0 = x0;
		it.x1 = x1;
		it.tgt = tgt;
		it.reload = rl;
		gap = in_gaps_on ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.feature_0 <= x0;
		in_ch.feature_1 <= x1;
		in_ch.target_value <= tgt;
		in_ch.reload <= rl;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		pending_results.push_back(train_step(it));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		apply_config(idx, data);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic wait_results();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (stall_left == 0 && out_stalls_on && $urandom_range(0, 99) < 30)
			stall_left = pick_gap();
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		neuron_result_t want;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			result_count++;
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d arrived with no sample pending", result_count));
			end else begin
				want = pending_results.pop_front();
				check_field("prediction", out_ch.prediction, want.pred);
				check_field("squared_error", out_ch.squared_error, want.sqerr);
				check_field("grad_bias", out_ch.grad_bias, want.gb);
				check_field("grad_weight0", out_ch.grad_weight0, want.gw0);
				check_field("grad_weight1", out_ch.grad_weight1, want.gw1);
				check_field("clipped", 16'(out_ch.clipped), 16'(want.clip));
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	function automatic logic signed [DATA_W-1:0] rand_feature();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return Q_MIN;
					1: return Q_MAX;
					2: return 16'sd0;
					default: return -16'sd1;
				endcase
			end
			1, 2: return 16'($urandom);
			default: return 16'($urandom_range(0, 16384) - 8192);
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_target();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 16'($urandom_range(0, 4096));
		if (r < 8) return 16'($urandom_range(0, 16384) - 8192);
		return 16'($urandom);
	endfunction

	function automatic logic [DATA_W-1:0] rand_init();
		if ($urandom_range(0, 3) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	// reset parameters, no register written yet
	task automatic test_reset_state();
		send_item(16'sd4096, 16'sd4096, 16'sd2048, 1'b0);
		send_item(-16'sd4096, 16'sd8192, 16'sd0, 1'b0);
		send_item(16'sd0, 16'sd0, 16'sd4096, 1'b1);
	endtask

	// z clamped both ways, large error, gradient overflow
	task automatic test_field_extremes();
		send_item(Q_MAX, Q_MIN, 16'sd0, 1'b0);
		send_item(Q_MAX, Q_MAX, Q_MAX, 1'b0);
		send_item(Q_MIN, Q_MIN, Q_MIN, 1'b0);
		send_item(-16'sd1, -16'sd1, -16'sd1, 1'b0);
		send_item(16'sd0, 16'sd0, 16'sd0, 1'b1);
		send_item(Q_MIN, Q_MAX, Q_MAX, 1'b1);
	endtask

	task automatic test_config_regs();
		wait_results();
		// learn_rate upper data bits dropped, step above one
		write_reg(CFG_LEARN_RATE, 16'hFFFF);
		write_reg(CFG_INIT_W0, 16'h7FFF);
		write_reg(CFG_INIT_W1, 16'h8000);
		write_reg(CFG_INIT_BIAS, 16'h7FFF);
		send_item(Q_MAX, Q_MIN, Q_MIN, 1'b1);
		send_item(Q_MIN, Q_MAX, Q_MAX, 1'b0);
		send_item(16'sd4096, -16'sd4096, 16'sd0, 1'b0);
		wait_results();
		// zero step and a write to an unused index: parameters hold
		write_reg(CFG_LEARN_RATE, 16'd0);
		write_reg(CFG_FIRST_UNUSED, 16'h1234);
		send_item(16'sd8192, 16'sd8192, 16'sd4096, 1'b1);
		send_item(16'sd8192, 16'sd8192, 16'sd4096, 1'b0);
		wait_results();
		write_reg(CFG_LEARN_RATE, 16'd4096);
		write_reg(CFG_INIT_W0, 16'h8000);
		write_reg(CFG_INIT_W1, 16'h8000);
		write_reg(CFG_INIT_BIAS, 16'h8000);
		send_item(Q_MAX, Q_MAX, Q_MAX, 1'b1);
		send_item(Q_MIN, 16'sd0, 16'sd0, 1'b0);
		wait_results();
		write_reg(CFG_LEARN_RATE, 16'(RST_LEARN_RATE));
		write_reg(CFG_INIT_W0, RST_WEIGHT_0);
		write_reg(CFG_INIT_W1, RST_WEIGHT_1);
		write_reg(CFG_INIT_BIAS, RST_BIAS);
		send_item(16'sd4096, 16'sd4096, 16'sd2048, 1'b1);
	endtask

	// training runs: a reload, then a run of samples, with some stray reloads
	task automatic test_random_training();
		int               phase, n, run_left;
		logic [DATA_W-1:0] lr;
		logic             rl;
		run_left = 0;
		for (phase = 0; phase < PHASES; phase++) begin
			wait_results();
			case (phase)
				0: lr = 16'd4096;
				1: lr = 16'hFFFF;
				2: lr = 16'd0;
				default: lr = ($urandom_range(0, 3) == 0) ? 16'($urandom)
					: 16'($urandom_range(1, 2048));
			endcase
			write_reg(CFG_LEARN_RATE, lr);
			write_reg(CFG_INIT_W0, rand_init());
			write_reg(CFG_INIT_W1, rand_init());
			write_reg(CFG_INIT_BIAS, rand_init());
			write_reg(CFG_FIRST_UNUSED + 4'($urandom_range(0, 15 - CFG_FIRST_UNUSED)),
				16'($urandom));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0) begin
					in_gaps_on = ($urandom_range(0, 3) != 0);
					out_stalls_on = ($urandom_range(0, 3) != 0);
				end
				if (n == 75) wait_results();
				if (run_left == 0) begin
					rl = 1'b1;
					run_left = $urandom_range(5, 40);
				end else begin
					rl = ($urandom_range(0, 19) == 0);
					run_left--;
				end
				send_item(rand_feature(), rand_feature(), rand_target(), rl);
			end
		end
		in_gaps_on = 1'b1;
		out_stalls_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.feature_0 = '0;
		in_ch.feature_1 = '0;
		in_ch.target_value = '0;
		in_ch.reload = 1'b0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;

		build_sig_lut();
		lr_st = RST_LEARN_RATE;
		init_w0_st = RST_WEIGHT_0;
		init_w1_st = RST_WEIGHT_1;
		init_b_st = RST_BIAS;
		w0_st = RST_WEIGHT_0;
		w1_st = RST_WEIGHT_1;
		b_st = RST_BIAS;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_field_extremes();
		test_config_regs();
		test_random_training();
		wait_results();

		if (mismatches == 0) begin
			$display("** sigmoid_neuron_sgd_step: PASSED **");
		end else begin
			$display("** sigmoid_neuron_sgd_step: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sigmoid_neuron_sgd_step.f =====
design/sns_pkg.sv
design/sns_in_if.sv
design/sns_out_if.sv
design/sns_cfg_if.sv
design/sns_mul.sv
design/sns_seq.sv
design/sigmoid_neuron_sgd_step.sv
design/sns_checker.sv
verif/sigmoid_neuron_sgd_step_tb.sv
